### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is asserted.
`define PFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define PFM_ASSERT_NEVER(lbl, cond, msg) \
  `PFM_ASSERT(lbl, !(cond), msg)

`endif

### hdl/pfm251_pkg.sv
package pfm251_pkg;

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_INV = 3'd4;
  localparam logic [2:0] FUNC_RED = 3'd5;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] field_result;
    logic       no_inverse;
  } out_item_t;

  // Smallest x in 1..m-1 with r*x = 1 mod m, or 0 when none exists.
  // r must already lie below m.
  function automatic logic [7:0] fld_inv(input int unsigned r, input int unsigned m);
    int unsigned acc;
    logic [7:0]  res;
    acc = 0;
    res = '0;
    for (int unsigned x = 1; x < 256; x++) begin
      acc = acc + r;
      if (acc >= m) begin
        acc = acc - m;
      end
      if ((x < m) && (acc == 1) && (res == '0)) begin
        res = 8'(x);
      end
    end
    return res;
  endfunction

endpackage

### hdl/prime_field_mod251_alu.sv
// Arithmetic unit over the integers modulo MODULUS (prime 251 by default).
// Input channel in_valid/in_stall/in_data carries one transaction per item:
// an operation code (add, subtract, multiply, divide, inverse of a, reduce a)
// and two byte operands, both reduced modulo MODULUS before use.
// Output channel out_valid/out_stall/out_data returns exactly one transaction
// per input: field_result in 0..MODULUS-1 and no_inverse, set when divide or
// inverse meets an element without inverse (result is then 0).
// Path: an accepted transaction passes the input register, then the result
// register, which drives out_valid; reduction, inverse ROM and multiplier sit between.
// Throughput: one transaction per cycle, sustained while out_stall is low.
// Stall: while out_stall holds a pending result, one more transaction is taken
// into the input register; in_stall rises only when both registers are full.
// Reset (rst_n low, synchronous) empties both stages; the block keeps no
// other state, so no warm-up is needed after reset.
`include "assert_macros.svh"

module prime_field_mod251_alu #(
  parameter int MODULUS = 251
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pfm251_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pfm251_pkg::out_item_t out_data
);

  import pfm251_pkg::*;

  in_item_t  s1_r,     s1_nxt;
  logic      s1_vld_r, s1_vld_nxt;
  out_item_t s2_r,     s2_nxt;
  logic      s2_vld_r, s2_vld_nxt;
  out_item_t core_res;
  logic      s1_free;
  logic      s2_free;

  pfm251_core #(
    .MODULUS(MODULUS)
  ) u_core (
    .item (s1_r),
    .res  (core_res)
  );

  assign s2_free = !s2_vld_r || !out_stall;
  assign s1_free = !s1_vld_r || s2_free;

  always_comb begin
    s1_nxt     = s1_r;
    s1_vld_nxt = s1_vld_r;
    s2_nxt     = s2_r;
    s2_vld_nxt = s2_vld_r;
    if (s1_free) begin
      s1_vld_nxt = in_valid;
      if (in_valid) begin
        s1_nxt = in_data;
      end
    end
    if (s2_free) begin
      s2_vld_nxt = s1_vld_r;
      if (s1_vld_r) begin
        s2_nxt = core_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    s2_r <= s2_nxt;
  end

  assign in_stall  = !s1_free;
  assign out_valid = s2_vld_r;
  assign out_data  = s2_r;

  `PFM_ASSERT(a_result_range,
    out_valid |-> (out_data.field_result < 8'(MODULUS)), "result out of field range")
  `PFM_ASSERT(a_flag_zero,
    (out_valid && out_data.no_inverse) |-> (out_data.field_result == '0),
    "no_inverse with nonzero result")
  `PFM_ASSERT_NEVER(a_no_overrun,
    s1_vld_r && out_valid && out_stall && !in_stall, "input taken with both stages full")
  `PFM_ASSERT(a_advance,
    (s1_vld_r && (!out_valid || !out_stall)) |=> out_valid,
    "pending transaction did not reach output")

endmodule

### hdl/pfm251_mulmod.sv
module pfm251_mulmod #(
  parameter int MODULUS = 251
) (
  input  logic [7:0] a,
  input  logic [7:0] b,
  output logic [7:0] prod
);

  localparam logic [8:0] MOD9 = 9'(MODULUS);

  logic [7:0]  hi_tbl [256];
  logic [7:0]  lo_tbl [256];
  logic [15:0] full;
  logic [8:0]  fold;

  // Residues of the high product byte weighted by 256 and of the low byte.
  for (genvar i = 0; i < 256; i++) begin : g_tbl
    assign hi_tbl[i] = 8'((i * 256) % MODULUS);
    assign lo_tbl[i] = 8'(i % MODULUS);
  end

  assign full = {8'b0, a} * {8'b0, b};

  always_comb begin
    fold = {1'b0, hi_tbl[full[15:8]]} + {1'b0, lo_tbl[full[7:0]]};
    if (fold >= MOD9) begin
      fold = fold - MOD9;
    end
  end

  assign prod = fold[7:0];

endmodule

### hdl/pfm251_core.sv
module pfm251_core #(
  parameter int MODULUS = 251
) (
  input  pfm251_pkg::in_item_t  item,
  output pfm251_pkg::out_item_t res
);

  import pfm251_pkg::*;

  localparam logic [8:0] MOD9 = 9'(MODULUS);

  logic [7:0] red_tbl [256];
  logic [7:0] inv_tbl [256];
  logic [7:0] a_red;
  logic [7:0] b_red;
  logic [7:0] inv_idx;
  logic [7:0] inv_val;
  logic [7:0] mul_b;
  logic [7:0] mul_out;
  logic [8:0] sum;
  logic [8:0] dif;

  for (genvar i = 0; i < 256; i++) begin : g_tbl
    assign red_tbl[i] = 8'(i % MODULUS);
    assign inv_tbl[i] = fld_inv(32'(i % MODULUS), 32'(MODULUS));
  end

  assign a_red   = red_tbl[item.operand_a];
  assign b_red   = red_tbl[item.operand_b];
  assign inv_idx = (item.func == FUNC_INV) ? a_red : b_red;
  assign inv_val = inv_tbl[inv_idx];
  assign mul_b   = (item.func == FUNC_DIV) ? inv_val : b_red;

  pfm251_mulmod #(
    .MODULUS(MODULUS)
  ) u_mulmod (
    .a    (a_red),
    .b    (mul_b),
    .prod (mul_out)
  );

  always_comb begin
    sum = {1'b0, a_red} + {1'b0, b_red};
    if (sum >= MOD9) begin
      sum = sum - MOD9;
    end
    dif = {1'b0, a_red} + MOD9 - {1'b0, b_red};
    if (dif >= MOD9) begin
      dif = dif - MOD9;
    end
  end

  always_comb begin
    res = '0;
    unique case (item.func)
      FUNC_ADD: res.field_result = sum[7:0];
      FUNC_SUB: res.field_result = dif[7:0];
      FUNC_MUL: res.field_result = mul_out;
      FUNC_DIV: begin
        res.field_result = mul_out;
        res.no_inverse   = (inv_val == '0);
      end
      FUNC_INV: begin
        res.field_result = inv_val;
        res.no_inverse   = (inv_val == '0);
      end
      FUNC_RED: res.field_result = a_red;
      default:  res = '0;
    endcase
  end

endmodule

### tb/tb_prime_field_mod251_alu.sv
module tb_prime_field_mod251_alu;
  timeunit 1ns;
  timeprecision 1ps;

  import pfm251_pkg::*;

  localparam int unsigned FIELD_P = 251;
  localparam logic [2:0] FUNC_RSVD6 = 3'd6;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;
  localparam int RANDOM_OPS = 500;
  localparam int CALM_TAIL = 100;
  localparam int LONG_HOLD = 200;
  localparam int CYCLE_LIMIT = 200000;

  class field_result_checker;
    out_item_t pending_results[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function bit field_recip(input int unsigned r, output int unsigned inv);
      inv = 0;
      for (int unsigned x = 1; x < FIELD_P; x++) begin
        if ((r * x) % FIELD_P == 1) begin
          inv = x;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function out_item_t field_compute(input in_item_t op);
      int unsigned ra;
      int unsigned rb;
      int unsigned res;
      int unsigned inv;
      out_item_t r;
      ra = op.operand_a % FIELD_P;
      rb = op.operand_b % FIELD_P;
      res = 0;
      r.no_inverse = 1'b0;
      case (op.func)
        FUNC_ADD: res = (ra + rb) % FIELD_P;
        FUNC_SUB: res = (ra + FIELD_P - rb) % FIELD_P;
        FUNC_MUL: res = (ra * rb) % FIELD_P;
        FUNC_DIV: begin
          if (field_recip(rb, inv)) res = (ra * inv) % FIELD_P;
          else r.no_inverse = 1'b1;
        end
        FUNC_INV: begin
          if (field_recip(ra, inv)) res = inv;
          else r.no_inverse = 1'b1;
        end
        FUNC_RED: res = ra;
        default: res = 0;
      endcase
      r.field_result = 8'(res);
      return r;
    endfunction

    function void note_operation(input in_item_t op);
      pending_results.push_back(field_compute(op));
    endfunction

    function void check_result(input out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction: field_result=%0d no_inverse=%0b",
                 $time, got.field_result, got.no_inverse);
        return;
      end
      want = pending_results.pop_front();
      if (got.field_result !== want.field_result) begin
        errors++;
        $display("%0t: field_result mismatch: expected %0d, actual %0d",
                 $time, want.field_result, got.field_result);
      end
      if (got.no_inverse !== want.no_inverse) begin
        errors++;
        $display("%0t: no_inverse mismatch: expected %0b, actual %0b",
                 $time, want.no_inverse, got.no_inverse);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;

  field_result_checker field_model;
  bit idle_enable;
  bit hold_request;
  int stall_left;
  int cycle_count = 0;

  prime_field_mod251_alu dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) field_model.check_result(out_data);
  end

  // result side: random stall bursts, or one long hold on request
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_op(input in_item_t op);
    if (idle_enable && !hold_request && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    field_model.note_operation(op);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [2:0] f, input logic [7:0] a, input logic [7:0] b);
    in_item_t op;
    op.func = f;
    op.operand_a = a;
    op.operand_b = b;
    send_op(op);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (field_model.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] corners[6] = '{8'd0, 8'd1, 8'd250, 8'd251, 8'd252, 8'd255};
    if ($urandom_range(0, 4) == 0) return corners[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [2:0] pick_func();
    if ($urandom_range(0, 15) == 0) return ($urandom_range(0, 1) != 0) ? FUNC_RSVD7 : FUNC_RSVD6;
    return 3'($urandom_range(0, 5));
  endfunction

  initial begin
    field_model = new();
    idle_enable = 1'b0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_fields(FUNC_ADD, 8'd250, 8'd250);
    send_fields(FUNC_ADD, 8'd255, 8'd255);
    send_fields(FUNC_SUB, 8'd0, 8'd1);
    send_fields(FUNC_SUB, 8'd251, 8'd250);
    send_fields(FUNC_SUB, 8'd255, 8'd0);
    send_fields(FUNC_MUL, 8'd255, 8'd255);
    send_fields(FUNC_MUL, 8'd250, 8'd250);
    send_fields(FUNC_MUL, 8'd0, 8'd255);
    send_fields(FUNC_DIV, 8'd7, 8'd0);
    send_fields(FUNC_DIV, 8'd255, 8'd251);
    send_fields(FUNC_DIV, 8'd1, 8'd250);
    send_fields(FUNC_DIV, 8'd252, 8'd255);
    send_fields(FUNC_INV, 8'd0, 8'd9);
    send_fields(FUNC_INV, 8'd251, 8'd0);
    send_fields(FUNC_INV, 8'd1, 8'd255);
    send_fields(FUNC_INV, 8'd250, 8'd0);
    send_fields(FUNC_INV, 8'd255, 8'd0);
    send_fields(FUNC_RED, 8'd255, 8'd255);
    send_fields(FUNC_RED, 8'd250, 8'd0);
    send_fields(FUNC_RSVD6, 8'd255, 8'd255);
    send_fields(FUNC_RSVD7, 8'd17, 8'd0);
    wait_drained();

    idle_enable = 1'b1;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == 150) hold_request = 1'b1;
      if (i == 300) wait_drained();
      if (i == RANDOM_OPS - CALM_TAIL) idle_enable = 1'b0;
      send_fields(pick_func(), pick_operand(), pick_operand());
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (field_model.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
